// ----- sv/uf2_block_sequence_checker_unit_assert.svh -----
// ----------------------------------------------------------------------------
// UF2 block sequence checker assertion macros
// Shared concurrent assertion forms, sampled on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef UF2_BLOCK_SEQUENCE_CHECKER_UNIT_ASSERT_SVH
`define UF2_BLOCK_SEQUENCE_CHECKER_UNIT_ASSERT_SVH

// same-cycle implication
`define UF2BSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UF2BSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/uf2bsc_pkg.sv -----
// ----------------------------------------------------------------------------
// UF2 block sequence checker package
// Widths, flash geometry, header constants, codes and the queue record.
// ----------------------------------------------------------------------------
package uf2bsc_pkg;

  // field widths
  localparam int WORD_W    = 32;
  localparam int ADDR_W    = 32;
  localparam int MODE_W    = 2;
  localparam int PEND_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int VERDICT_W = 3;
  localparam int SECTOR_W  = 9;
  localparam int SCOUNT_W  = 10;
  localparam int OFFSET_W  = 21;
  localparam int RSIZE_W   = 22;
  localparam int COUNT_W   = 14;

  // flash geometry
  localparam int unsigned     PAGE_BYTES   = 256;
  localparam int unsigned     SECTOR_BYTES = 4096;
  localparam logic [ADDR_W-1:0] FLASH_BASE = 32'h1000_0000;
  localparam int unsigned     FLASH_BYTES  = 2097152;
  localparam int unsigned     TAIL_BYTES   = 4;

  localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
  localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
  // wide enough for an address plus a page count of any size
  localparam int END_W        = ADDR_W + PAGE_SHIFT + 1;
  localparam logic [END_W-1:0] FLASH_END = END_W'(FLASH_BASE) + END_W'(FLASH_BYTES);
  localparam logic [WORD_W-1:0] COUNT_MAX = WORD_W'((1 << COUNT_W) - 1);

  // header constants
  localparam logic [WORD_W-1:0] MAGIC_FIRST  = 32'h0A32_4655;
  localparam logic [WORD_W-1:0] MAGIC_SECOND = 32'h9E5D_5157;
  localparam logic [WORD_W-1:0] MAGIC_LAST   = 32'h0AB1_6F30;
  localparam int FLAG_NOT_MAIN_BIT = 0;
  localparam int FLAG_FAMILY_BIT   = 13;

  // configuration reset values
  localparam logic [WORD_W-1:0] AREA_BEGIN_RST      = 32'h1000_0000;
  localparam logic [WORD_W-1:0] AREA_END_RST        = 32'h101F_0000;
  localparam logic [WORD_W-1:0] FAMILY_EXPECTED_RST = 32'hE48B_FF56;

  // item mode codes; anything else is an abort
  localparam logic [MODE_W-1:0] MODE_HEADER = 2'd0;
  localparam logic [MODE_W-1:0] MODE_END    = 2'd1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AREA_BEGIN      = 2'd0,
    CFG_AREA_END        = 2'd1,
    CFG_FAMILY_EXPECTED = 2'd2
  } cfg_reg_t;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_FIRST      = 3'd0,
    VERDICT_NEXT       = 3'd1,
    VERDICT_REJECT     = 3'd2,
    VERDICT_DONE       = 3'd3,
    VERDICT_EMPTY      = 3'd4,
    VERDICT_INCOMPLETE = 3'd5,
    VERDICT_ABORT      = 3'd6
  } verdict_t;

  typedef enum logic [1:0] {
    KIND_HEADER,
    KIND_END,
    KIND_ABORT
  } item_kind_t;

  // classified item passed from the front to the back
  typedef struct packed {
    item_kind_t          kind;
    logic                hdr_ok;
    logic                first_ok;
    logic [SECTOR_W-1:0] sector_first;
    logic [SCOUNT_W-1:0] sector_count;
    logic                keep_boot;
    logic                prog_first;
    logic [OFFSET_W-1:0] offset;
    logic [ADDR_W-1:0]   addr;
    logic [COUNT_W-1:0]  idx;
    logic                idx_fits;
    logic [COUNT_W-1:0]  total;
    logic                total_fits;
    logic                pending;
  } front_rec_t;

endpackage

// ----- sv/uf2bsc_if.sv -----
// ----------------------------------------------------------------------------
// UF2 block sequence checker channels
// Item, result and configuration write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface uf2bsc_in_if;
  import uf2bsc_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [WORD_W-1:0] magic_first;
  logic [WORD_W-1:0] magic_second;
  logic [WORD_W-1:0] magic_last;
  logic [WORD_W-1:0] flags;
  logic [ADDR_W-1:0] target_address;
  logic [WORD_W-1:0] payload_bytes;
  logic [WORD_W-1:0] block_index;
  logic [WORD_W-1:0] block_total;
  logic [WORD_W-1:0] family_tag;
  logic [PEND_W-1:0] pending_packets;

  modport source (
    output valid, mode, magic_first, magic_second, magic_last, flags, target_address,
           payload_bytes, block_index, block_total, family_tag, pending_packets,
    input  ready
  );
  modport sink (
    input  valid, mode, magic_first, magic_second, magic_last, flags, target_address,
           payload_bytes, block_index, block_total, family_tag, pending_packets,
    output ready
  );
endinterface

interface uf2bsc_out_if;
  import uf2bsc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [VERDICT_W-1:0] verdict;
  logic [SECTOR_W-1:0]  erase_sector_first;
  logic [SCOUNT_W-1:0]  erase_sector_count;
  logic                 keep_boot_area;
  logic                 program_page;
  logic [OFFSET_W-1:0]  program_offset;
  logic [ADDR_W-1:0]    record_address;
  logic [RSIZE_W-1:0]   record_size;

  modport source (
    output valid, verdict, erase_sector_first, erase_sector_count, keep_boot_area,
           program_page, program_offset, record_address, record_size,
    input  ready
  );
  modport sink (
    input  valid, verdict, erase_sector_first, erase_sector_count, keep_boot_area,
           program_page, program_offset, record_address, record_size,
    output ready
  );
endinterface

interface uf2bsc_cfg_if;
  import uf2bsc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/uf2bsc_front.sv -----
// ----------------------------------------------------------------------------
// UF2 block sequence checker front end
// Holds the configuration registers, accepts items and classifies headers
// against everything that does not depend on the session state.
// ----------------------------------------------------------------------------
module uf2bsc_front (
  input  logic                   clk,
  input  logic                   rst,
  uf2bsc_cfg_if.sink             cfg,
  uf2bsc_in_if.sink              item,
  output logic                   push_valid,
  input  logic                   push_ready,
  output uf2bsc_pkg::front_rec_t push_rec
);
  import uf2bsc_pkg::*;

  logic [WORD_W-1:0] area_begin;
  logic [WORD_W-1:0] area_end;
  logic [WORD_W-1:0] family_expected;

  logic [ADDR_W-1:0] addr;
  logic [END_W-1:0]  end_addr;
  logic [ADDR_W-1:0] offset;
  logic [END_W-1:0]  last_offset;
  logic [END_W-1:0]  s1;
  logic [END_W-1:0]  s2;
  logic              magic_ok;
  logic              family_ok;
  logic              range_ok;
  logic              hdr_ok;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      area_begin      <= AREA_BEGIN_RST;
      area_end        <= AREA_END_RST;
      family_expected <= FAMILY_EXPECTED_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_AREA_BEGIN:      area_begin      <= cfg.data;
        CFG_AREA_END:        area_end        <= cfg.data;
        CFG_FAMILY_EXPECTED: family_expected <= cfg.data;
        default: ;
      endcase
    end
  end

  assign addr     = item.target_address;
  assign end_addr = END_W'(addr) + (END_W'(item.block_total) << PAGE_SHIFT);
  assign offset   = addr - FLASH_BASE;
  // last word of the image decides the last sector
  assign last_offset = end_addr - END_W'(TAIL_BYTES) - END_W'(FLASH_BASE);
  assign s1 = END_W'(offset >> SECTOR_SHIFT);
  assign s2 = last_offset >> SECTOR_SHIFT;

  assign magic_ok  = (item.magic_first == MAGIC_FIRST) && (item.magic_second == MAGIC_SECOND)
                     && (item.magic_last == MAGIC_LAST);
  assign family_ok = !item.flags[FLAG_FAMILY_BIT] || (item.family_tag == family_expected);
  assign range_ok  = (addr >= area_begin) && (addr < area_end) && (addr >= FLASH_BASE)
                     && (END_W'(addr) < FLASH_END);

  assign hdr_ok = magic_ok && !item.flags[FLAG_NOT_MAIN_BIT]
                  && (addr[PAGE_SHIFT-1:0] == '0) && range_ok
                  && (item.payload_bytes == WORD_W'(PAGE_BYTES))
                  && (item.block_total != '0) && (item.block_index < item.block_total)
                  && family_ok;

  always_comb begin
    push_rec = '0;
    priority if (item.mode == MODE_HEADER) begin
      push_rec.kind = KIND_HEADER;
    end else if (item.mode == MODE_END) begin
      push_rec.kind = KIND_END;
    end else begin
      push_rec.kind = KIND_ABORT;
    end
    push_rec.hdr_ok       = hdr_ok;
    push_rec.first_ok     = hdr_ok && (item.block_index == '0)
                            && (end_addr <= END_W'(area_end)) && (end_addr <= FLASH_END)
                            && (item.block_total <= COUNT_MAX);
    push_rec.sector_first = s1[SECTOR_W-1:0];
    push_rec.sector_count = SCOUNT_W'(s2 - s1 + END_W'(1));
    push_rec.keep_boot    = (s1 == '0);
    push_rec.prog_first   = (addr != FLASH_BASE);
    push_rec.offset       = offset[OFFSET_W-1:0];
    push_rec.addr         = addr;
    push_rec.idx          = item.block_index[COUNT_W-1:0];
    push_rec.idx_fits     = (item.block_index <= COUNT_MAX);
    push_rec.total        = item.block_total[COUNT_W-1:0];
    push_rec.total_fits   = (item.block_total <= COUNT_MAX);
    push_rec.pending      = (item.pending_packets != '0);
  end

  assign push_valid = item.valid;
  assign item.ready = push_ready;

endmodule

// ----- sv/uf2bsc_queue.sv -----
// ----------------------------------------------------------------------------
// UF2 block sequence checker queue
// Short register FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module uf2bsc_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push_valid,
  output logic                   push_ready,
  input  uf2bsc_pkg::front_rec_t push_rec,
  output logic                   pop_valid,
  input  logic                   pop_ready,
  output uf2bsc_pkg::front_rec_t pop_rec
);
  import uf2bsc_pkg::*;

  front_rec_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCOUNT_W-1:0] count;
  logic                push;
  logic                pop;

  assign push_ready = (count != QCOUNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_rec    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + QCOUNT_W'(1);
        2'b01:   count <= count - QCOUNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/uf2bsc_back.sv -----
// ----------------------------------------------------------------------------
// UF2 block sequence checker back end
// Keeps the session state, settles each queued item into a verdict and holds
// the result in the output register until it is taken.
// ----------------------------------------------------------------------------
module uf2bsc_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pop_valid,
  output logic                   pop_ready,
  input  uf2bsc_pkg::front_rec_t pop_rec,
  uf2bsc_out_if.source           result
);
  import uf2bsc_pkg::*;

  logic [ADDR_W-1:0]  base_address;
  logic [COUNT_W-1:0] total_blocks;
  logic [COUNT_W-1:0] blocks_received;
  logic [ADDR_W-1:0]  base_address_next;
  logic [COUNT_W-1:0] total_blocks_next;
  logic [COUNT_W-1:0] blocks_received_next;

  logic                res_valid;
  verdict_t            verdict;
  logic [SECTOR_W-1:0] sector_first;
  logic [SCOUNT_W-1:0] sector_count;
  logic                keep_boot;
  logic                prog;
  logic [OFFSET_W-1:0] prog_offset;
  logic [ADDR_W-1:0]   rec_address;
  logic [RSIZE_W-1:0]  rec_size;

  verdict_t            verdict_next;
  logic [SECTOR_W-1:0] sector_first_next;
  logic [SCOUNT_W-1:0] sector_count_next;
  logic                keep_boot_next;
  logic                prog_next;
  logic [OFFSET_W-1:0] prog_offset_next;
  logic [ADDR_W-1:0]   rec_address_next;
  logic [RSIZE_W-1:0]  rec_size_next;

  logic [ADDR_W:0] expect_addr;
  logic            next_ok;
  logic            pop;

  assign pop_ready = !res_valid || result.ready;
  assign pop       = pop_valid && pop_ready;

  assign expect_addr = (ADDR_W + 1)'(base_address)
                       + ((ADDR_W + 1)'(blocks_received) << PAGE_SHIFT);
  assign next_ok = pop_rec.hdr_ok && pop_rec.total_fits && (pop_rec.total == total_blocks)
                   && pop_rec.idx_fits && (pop_rec.idx == blocks_received)
                   && ((ADDR_W + 1)'(pop_rec.addr) == expect_addr);

  always_comb begin
    verdict_next         = VERDICT_ABORT;
    sector_first_next    = '0;
    sector_count_next    = '0;
    keep_boot_next       = 1'b0;
    prog_next            = 1'b0;
    prog_offset_next     = '0;
    rec_address_next     = '0;
    rec_size_next        = '0;
    base_address_next    = '0;
    total_blocks_next    = '0;
    blocks_received_next = '0;
    unique case (pop_rec.kind)
      KIND_HEADER: begin
        if (blocks_received == '0) begin
          if (pop_rec.first_ok) begin
            verdict_next         = VERDICT_FIRST;
            sector_first_next    = pop_rec.sector_first;
            sector_count_next    = pop_rec.sector_count;
            keep_boot_next       = pop_rec.keep_boot;
            prog_next            = pop_rec.prog_first;
            prog_offset_next     = pop_rec.prog_first ? pop_rec.offset : '0;
            base_address_next    = pop_rec.addr;
            total_blocks_next    = pop_rec.total;
            blocks_received_next = COUNT_W'(1);
          end else begin
            verdict_next = VERDICT_REJECT;
          end
        end else if (next_ok) begin
          verdict_next         = VERDICT_NEXT;
          prog_next            = 1'b1;
          prog_offset_next     = pop_rec.offset;
          base_address_next    = base_address;
          total_blocks_next    = total_blocks;
          blocks_received_next = blocks_received + COUNT_W'(1);
        end else begin
          verdict_next = VERDICT_REJECT;
        end
      end
      KIND_END: begin
        priority if (total_blocks == '0) begin
          verdict_next = VERDICT_EMPTY;
        end else if ((total_blocks != blocks_received) || pop_rec.pending) begin
          verdict_next = VERDICT_INCOMPLETE;
        end else begin
          verdict_next     = VERDICT_DONE;
          rec_address_next = base_address;
          rec_size_next    = RSIZE_W'(WORD_W'(total_blocks) << PAGE_SHIFT);
        end
      end
      KIND_ABORT: begin
        verdict_next = VERDICT_ABORT;
      end
      default: begin
        verdict_next = VERDICT_ABORT;
      end
    endcase
  end

  // session state and output register advance only on a pop
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address    <= '0;
      total_blocks    <= '0;
      blocks_received <= '0;
      res_valid       <= 1'b0;
    end else begin
      if (pop) begin
        base_address    <= base_address_next;
        total_blocks    <= total_blocks_next;
        blocks_received <= blocks_received_next;
        res_valid       <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      verdict      <= verdict_next;
      sector_first <= sector_first_next;
      sector_count <= sector_count_next;
      keep_boot    <= keep_boot_next;
      prog         <= prog_next;
      prog_offset  <= prog_offset_next;
      rec_address  <= rec_address_next;
      rec_size     <= rec_size_next;
    end
  end

  assign result.valid              = res_valid;
  assign result.verdict            = verdict;
  assign result.erase_sector_first = sector_first;
  assign result.erase_sector_count = sector_count;
  assign result.keep_boot_area     = keep_boot;
  assign result.program_page       = prog;
  assign result.program_offset     = prog_offset;
  assign result.record_address     = rec_address;
  assign result.record_size        = rec_size;

endmodule

// ----- sv/uf2_block_sequence_checker_unit.sv -----
// ----------------------------------------------------------------------------
// UF2 block sequence checker
// Follows a firmware-update session of UF2 block headers and link events.
//
//   channel  dir  beat
//   cfg      in   one register write (index, data)
//   item     in   one header, end of transfer or abort
//   result   out  one verdict with erase, program and record fields
//
// One item per cycle sustained while results are taken; each taken item is
// written into the queue and then settled into the output register.
// Reset is one cycle of rst; no clearing pass follows.
// item.ready drops only when the two-entry queue is full; the back stops
// popping while an untaken result sits in the output register.
// ----------------------------------------------------------------------------
`include "uf2_block_sequence_checker_unit_assert.svh"

module uf2_block_sequence_checker_unit (
  input  logic         clk,
  input  logic         rst,
  uf2bsc_cfg_if.sink   cfg,
  uf2bsc_in_if.sink    item,
  uf2bsc_out_if.source result
);
  import uf2bsc_pkg::*;

  logic       push_valid;
  logic       push_ready;
  front_rec_t push_rec;
  logic       pop_valid;
  logic       pop_ready;
  front_rec_t pop_rec;

  uf2bsc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_rec   (push_rec)
  );

  uf2bsc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_rec   (push_rec),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_rec    (pop_rec)
  );

  uf2bsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_rec   (pop_rec),
    .result    (result)
  );

  `UF2BSC_ASSERT_NOW(a_first_erases, result.valid && (result.verdict == VERDICT_FIRST), result.erase_sector_count != '0, "first block with no sector to erase")
  `UF2BSC_ASSERT_NOW(a_record_on_done, result.valid && (result.verdict != VERDICT_DONE), (result.record_address == '0) && (result.record_size == '0), "record fields set without done")
  `UF2BSC_ASSERT_NOW(a_program_on_accept, result.valid && result.program_page, (result.verdict == VERDICT_FIRST) || (result.verdict == VERDICT_NEXT), "page programmed on a non-accept verdict")
  `UF2BSC_ASSERT_NEXT(a_hold_no_pop, result.valid && !result.ready, result.valid && $stable(result.verdict), "result dropped or changed while stalled")

endmodule

// ----- test/uf2_block_sequence_checker_unit_test.sv -----
// ----------------------------------------------------------------------------
// UF2 block sequence checker testbench
// Drives block headers, end-of-transfer and abort events through the item
// channel under several area and family settings and with random gaps on
// both sides. A local session tracker predicts each verdict, and every
// result is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module uf2_block_sequence_checker_unit_test;
  import uf2bsc_pkg::*;

  localparam logic [MODE_W-1:0] MODE_ABORT = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int HALF_PERIOD = 2;
  localparam int TAIL_CYCLES = 8;
  localparam int MAX_REPORTS = 10;
  localparam int RUN_LIMIT   = 2000000;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [WORD_W-1:0] magic_first;
    logic [WORD_W-1:0] magic_second;
    logic [WORD_W-1:0] magic_last;
    logic [WORD_W-1:0] flags;
    logic [ADDR_W-1:0] target_address;
    logic [WORD_W-1:0] payload_bytes;
    logic [WORD_W-1:0] block_index;
    logic [WORD_W-1:0] block_total;
    logic [WORD_W-1:0] family_tag;
    logic [PEND_W-1:0] pending_packets;
  } update_item_t;

  typedef struct packed {
    verdict_t            verdict;
    logic [SECTOR_W-1:0] sector_first;
    logic [SCOUNT_W-1:0] sector_count;
    logic                keep_boot;
    logic                prog_page;
    logic [OFFSET_W-1:0] prog_offset;
    logic [ADDR_W-1:0]   rec_address;
    logic [RSIZE_W-1:0]  rec_size;
  } session_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  uf2bsc_cfg_if cfg ();
  uf2bsc_in_if  item ();
  uf2bsc_out_if result ();

  uf2_block_sequence_checker_unit uut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (item),
    .result (result)
  );

  // driven values, known from time zero
  logic              cfg_valid = 1'b0;
  cfg_reg_t          cfg_index = CFG_AREA_BEGIN;
  logic [WORD_W-1:0] cfg_data  = '0;
  logic              hdr_valid = 1'b0;
  update_item_t      hdr_word  = '0;
  logic              res_ready = 1'b0;

  assign cfg.valid            = cfg_valid;
  assign cfg.index            = cfg_index;
  assign cfg.data             = cfg_data;
  assign item.valid           = hdr_valid;
  assign item.mode            = hdr_word.mode;
  assign item.magic_first     = hdr_word.magic_first;
  assign item.magic_second    = hdr_word.magic_second;
  assign item.magic_last      = hdr_word.magic_last;
  assign item.flags           = hdr_word.flags;
  assign item.target_address  = hdr_word.target_address;
  assign item.payload_bytes   = hdr_word.payload_bytes;
  assign item.block_index     = hdr_word.block_index;
  assign item.block_total     = hdr_word.block_total;
  assign item.family_tag      = hdr_word.family_tag;
  assign item.pending_packets = hdr_word.pending_packets;
  assign result.ready         = res_ready;

  // settings the stimulus is built for
  logic [WORD_W-1:0] gen_begin  = AREA_BEGIN_RST;
  logic [WORD_W-1:0] gen_end    = AREA_END_RST;
  logic [WORD_W-1:0] gen_family = FAMILY_EXPECTED_RST;

  // tracker copy of the registers and the session
  logic [WORD_W-1:0]  area_lo;
  logic [WORD_W-1:0]  area_hi;
  logic [WORD_W-1:0]  family_want;
  logic [ADDR_W-1:0]  sess_base;
  logic [COUNT_W-1:0] sess_total;
  logic [COUNT_W-1:0] sess_count;

  update_item_t    pending_items[$];
  session_result_t awaited_verdicts[$];

  int unsigned queued_items = 0;
  int unsigned taken_items  = 0;
  int unsigned cfg_writes   = 0;
  int unsigned result_count = 0;
  int unsigned mismatches   = 0;
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct    = 0;
  bit          item_taken   = 1'b0;

  always #HALF_PERIOD clk = ~clk;

  function automatic void end_session();
    sess_base  = '0;
    sess_total = '0;
    sess_count = '0;
  endfunction

  function automatic session_result_t judge_item(update_item_t it);
    session_result_t r;
    logic [63:0] addr, idx, total, fin, s1, s2, flash_end;
    logic fine;
    r = '0;
    r.verdict = VERDICT_ABORT;
    addr = 64'(it.target_address);
    idx = 64'(it.block_index);
    total = 64'(it.block_total);
    flash_end = 64'(FLASH_END);
    if (it.mode == MODE_HEADER) begin
      fine = it.magic_first == MAGIC_FIRST && it.magic_second == MAGIC_SECOND
          && it.magic_last == MAGIC_LAST && !it.flags[FLAG_NOT_MAIN_BIT]
          && addr % 64'(PAGE_BYTES) == 0
          && addr >= 64'(area_lo) && addr < 64'(area_hi)
          && addr >= 64'(FLASH_BASE) && addr < flash_end
          && it.payload_bytes == PAGE_BYTES && total != 0 && idx < total
          && !(it.flags[FLAG_FAMILY_BIT] && it.family_tag != family_want);
      if (sess_count == 0) begin
        // the whole image has to fit, and the count must fit the counters
        fin = addr + 64'(PAGE_BYTES) * total;
        if (idx != 0 || fin > 64'(area_hi) || fin > flash_end || total > 64'(COUNT_MAX))
          fine = 1'b0;
        if (fine) begin
          s1 = (addr - 64'(FLASH_BASE)) / 64'(SECTOR_BYTES);
          s2 = (fin - 64'(TAIL_BYTES) - 64'(FLASH_BASE)) / 64'(SECTOR_BYTES);
          r.verdict = VERDICT_FIRST;
          r.sector_first = SECTOR_W'(s1);
          r.sector_count = SCOUNT_W'(s2 - s1 + 1);
          r.keep_boot = (s1 == 0);
          // the boot page itself is restored, not programmed
          if (addr != 64'(FLASH_BASE)) begin
            r.prog_page = 1'b1;
            r.prog_offset = OFFSET_W'(addr - 64'(FLASH_BASE));
          end
          sess_base = it.target_address;
          sess_total = COUNT_W'(total);
          sess_count = COUNT_W'(1);
        end
      end else begin
        if (total != 64'(sess_total) || idx != 64'(sess_count)
            || addr != 64'(sess_base) + 64'(PAGE_BYTES) * 64'(sess_count))
          fine = 1'b0;
        if (fine) begin
          r.verdict = VERDICT_NEXT;
          r.prog_page = 1'b1;
          r.prog_offset = OFFSET_W'(addr - 64'(FLASH_BASE));
          sess_count = sess_count + COUNT_W'(1);
        end
      end
      if (!fine) begin
        r.verdict = VERDICT_REJECT;
        end_session();
      end
    end else if (it.mode == MODE_END) begin
      if (sess_total == 0) begin
        r.verdict = VERDICT_EMPTY;
      end else if (sess_total != sess_count || it.pending_packets != 0) begin
        r.verdict = VERDICT_INCOMPLETE;
      end else begin
        r.verdict = VERDICT_DONE;
        r.rec_address = sess_base;
        r.rec_size = RSIZE_W'(64'(PAGE_BYTES) * 64'(sess_total));
      end
      end_session();
    end else begin
      end_session();
    end
    return r;
  endfunction

  function automatic bit differs(string name, logic [63:0] want, logic [63:0] got);
    if (want === got)
      return 1'b0;
    if (mismatches < MAX_REPORTS)
      $display("result %0d %s: expected %0h, got %0h", result_count, name, want, got);
    return 1'b1;
  endfunction

  task automatic check_verdict();
    session_result_t want, got;
    bit bad;
    got = {result.verdict, result.erase_sector_first, result.erase_sector_count,
           result.keep_boot_area, result.program_page, result.program_offset,
           result.record_address, result.record_size};
    result_count++;
    if (awaited_verdicts.size() == 0) begin
      if (mismatches < MAX_REPORTS)
        $display("result %0d arrived with nothing awaited", result_count);
      mismatches++;
    end else begin
      want = awaited_verdicts.pop_front();
      bad = 1'b0;
      bad |= differs("verdict", want.verdict, got.verdict);
      bad |= differs("erase_sector_first", want.sector_first, got.sector_first);
      bad |= differs("erase_sector_count", want.sector_count, got.sector_count);
      bad |= differs("keep_boot_area", want.keep_boot, got.keep_boot);
      bad |= differs("program_page", want.prog_page, got.prog_page);
      bad |= differs("program_offset", want.prog_offset, got.prog_offset);
      bad |= differs("record_address", want.rec_address, got.rec_address);
      bad |= differs("record_size", want.rec_size, got.rec_size);
      if (bad)
        mismatches++;
    end
  endtask

  // sample every handshake at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      area_lo = AREA_BEGIN_RST;
      area_hi = AREA_END_RST;
      family_want = FAMILY_EXPECTED_RST;
      end_session();
      item_taken = 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_AREA_BEGIN:      area_lo = cfg.data;
          CFG_AREA_END:        area_hi = cfg.data;
          CFG_FAMILY_EXPECTED: family_want = cfg.data;
          default: ;
        endcase
        cfg_writes++;
      end
      if (result.valid && result.ready)
        check_verdict();
      item_taken = item.valid && item.ready;
      if (item_taken) begin
        awaited_verdicts.push_back(judge_item(hdr_word));
        taken_items++;
      end
    end
  end

  // hold the item until its transfer, then advance or idle
  always @(negedge clk) begin
    if (rst) begin
      hdr_valid <= 1'b0;
    end else if (!hdr_valid || item_taken) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        hdr_word <= pending_items.pop_front();
        hdr_valid <= 1'b1;
      end else begin
        hdr_valid <= 1'b0;
      end
    end
    res_ready <= !rst && $urandom_range(99) >= stall_pct;
  end

  function automatic void enqueue(update_item_t it);
    pending_items.push_back(it);
    queued_items++;
  endfunction

  function automatic update_item_t random_item();
    update_item_t it;
    it.mode = MODE_W'($urandom_range(3));
    it.magic_first = $urandom();
    it.magic_second = $urandom();
    it.magic_last = $urandom();
    it.flags = $urandom();
    it.target_address = $urandom();
    it.payload_bytes = $urandom();
    it.block_index = $urandom();
    it.block_total = $urandom();
    it.family_tag = $urandom();
    it.pending_packets = PEND_W'($urandom_range(3));
    return it;
  endfunction

  function automatic update_item_t link_item(logic [MODE_W-1:0] mode,
                                             logic [PEND_W-1:0] pend);
    update_item_t it;
    it = random_item();
    it.mode = mode;
    it.pending_packets = pend;
    return it;
  endfunction

  function automatic update_item_t block_header(logic [ADDR_W-1:0] addr,
                                                logic [WORD_W-1:0] idx, total);
    update_item_t it;
    it = random_item();
    it.mode = MODE_HEADER;
    it.magic_first = MAGIC_FIRST;
    it.magic_second = MAGIC_SECOND;
    it.magic_last = MAGIC_LAST;
    it.flags[FLAG_NOT_MAIN_BIT] = 1'b0;
    it.target_address = addr;
    it.payload_bytes = PAGE_BYTES;
    it.block_index = idx;
    it.block_total = total;
    if (it.flags[FLAG_FAMILY_BIT])
      it.family_tag = gen_family;
    return it;
  endfunction

  // break one field of an otherwise good header
  function automatic update_item_t spoil(update_item_t it);
    int unsigned bitpos;
    bitpos = $urandom_range(31);
    case ($urandom_range(8))
      0: it.magic_first[bitpos] = ~it.magic_first[bitpos];
      1: it.magic_second[bitpos] = ~it.magic_second[bitpos];
      2: it.magic_last[bitpos] = ~it.magic_last[bitpos];
      3: it.flags[FLAG_NOT_MAIN_BIT] = 1'b1;
      4: it.target_address[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom_range(1, PAGE_BYTES - 1));
      5: it.payload_bytes[bitpos] = ~it.payload_bytes[bitpos];
      6: it.block_index = it.block_index + $urandom_range(1, 3);
      7: it.block_total[bitpos] = ~it.block_total[bitpos];
      default: begin
        it.flags[FLAG_FAMILY_BIT] = 1'b1;
        it.family_tag = gen_family ^ (32'd1 << bitpos);
      end
    endcase
    return it;
  endfunction

  function automatic update_item_t stray_header();
    update_item_t it;
    it = block_header(FLASH_BASE + PAGE_BYTES * $urandom_range(FLASH_BYTES / PAGE_BYTES - 1),
                      $urandom_range(2), $urandom_range(3));
    if ($urandom_range(1))
      it = spoil(it);
    return it;
  endfunction

  task automatic queue_session();
    update_item_t it;
    logic [63:0] lo, hi;
    logic [ADDR_W-1:0] base;
    int unsigned pages, total, start, sent, spoilt, closing;
    lo = 64'(gen_begin) > 64'(FLASH_BASE) ? 64'(gen_begin) : 64'(FLASH_BASE);
    lo = (lo + 64'(PAGE_BYTES) - 1) / 64'(PAGE_BYTES) * 64'(PAGE_BYTES);
    hi = 64'(gen_end) < 64'(FLASH_END) ? 64'(gen_end) : 64'(FLASH_END);
    if (hi < lo + 64'(PAGE_BYTES)) begin
      enqueue(stray_header());
    end else begin
      pages = 32'((hi - lo) / 64'(PAGE_BYTES));
      if (pages <= 8 || $urandom_range(9) == 0)
        total = $urandom_range(1, pages);
      else
        total = $urandom_range(1, 8);
      start = $urandom_range(0, pages - total);
      base = ADDR_W'(lo + 64'(start) * 64'(PAGE_BYTES));
      // long images are declared in full but cut short
      sent = total;
      if (total > 64)
        sent = $urandom_range(1, 6);
      else if ($urandom_range(5) == 0)
        sent = $urandom_range(0, total);
      spoilt = ($urandom_range(7) == 0) ? $urandom_range(0, total) : total;
      for (int unsigned i = 0; i < sent; i++) begin
        it = block_header(base + PAGE_BYTES * i, i, total);
        if (i == spoilt)
          it = spoil(it);
        enqueue(it);
      end
      closing = $urandom_range(19);
      if (closing < 13)
        enqueue(link_item(MODE_END, '0));
      else if (closing < 16)
        enqueue(link_item(MODE_END, PEND_W'($urandom_range(3))));
      else if (closing == 16)
        enqueue(link_item(MODE_ABORT, PEND_W'($urandom_range(3))));
      else if (closing == 17)
        enqueue(link_item(MODE_SPARE, PEND_W'($urandom_range(3))));
      // otherwise leave the session open for the next one to run into
    end
  endtask

  task automatic queue_random(int unsigned count);
    int unsigned goal;
    goal = queued_items + count;
    while (queued_items < goal) begin
      case ($urandom_range(9))
        0:       enqueue(random_item());
        1:       enqueue(stray_header());
        default: queue_session();
      endcase
    end
  endtask

  task automatic drain();
    do
      @(negedge clk);
    while (taken_items != queued_items || awaited_verdicts.size() != 0);
  endtask

  task automatic run_phase(int unsigned gap, int unsigned stall, int unsigned count);
    @(posedge clk);
    send_gap_pct = gap;
    stall_pct = stall;
    queue_random(count);
    drain();
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [WORD_W-1:0] value);
    int unsigned target;
    target = cfg_writes + 1;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    wait (cfg_writes == target);
  endtask

  task automatic set_config(logic [WORD_W-1:0] a_begin, a_end, fam);
    write_reg(CFG_AREA_BEGIN, a_begin);
    write_reg(CFG_AREA_END, a_end);
    write_reg(CFG_FAMILY_EXPECTED, fam);
    @(negedge clk);
    cfg_valid <= 1'b0;
    gen_begin = a_begin;
    gen_end = a_end;
    gen_family = fam;
  endtask

  initial begin
    update_item_t it;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // link events with no session open
    enqueue(link_item(MODE_END, 2'd3));
    enqueue(link_item(MODE_ABORT, '0));
    enqueue(link_item(MODE_SPARE, '0));
    // boot page as the whole image, then a clean finish
    enqueue(block_header(FLASH_BASE, 0, 1));
    enqueue(link_item(MODE_END, '0));
    // last page of the area, finished with a packet still held
    enqueue(block_header(AREA_END_RST - PAGE_BYTES, 0, 1));
    enqueue(link_item(MODE_END, 2'd1));
    // a session broken by an address gap
    enqueue(block_header(32'h1000_1000, 0, 3));
    enqueue(block_header(32'h1000_1100, 1, 3));
    enqueue(block_header(32'h1000_1300, 2, 3));
    enqueue(link_item(MODE_END, '0));
    // counts beyond the counters and images beyond the area or the flash
    enqueue(block_header(32'h1000_0100, 0, '1));
    enqueue(block_header(32'h1000_0100, 0, 32'(COUNT_MAX) + 1));
    enqueue(block_header(AREA_END_RST - PAGE_BYTES, 0, 2));
    enqueue(block_header(FLASH_BASE - PAGE_BYTES, 0, 1));
    enqueue(block_header('1 - (PAGE_BYTES - 1), '1, '1));
    enqueue(block_header(FLASH_BASE, 0, 0));
    enqueue(block_header(FLASH_BASE, 1, 2));
    // one bad header field at a time
    it = block_header(FLASH_BASE, 0, 1);
    it.magic_first = ~MAGIC_FIRST;
    enqueue(it);
    it = block_header(FLASH_BASE, 0, 1);
    it.magic_second = ~MAGIC_SECOND;
    enqueue(it);
    it = block_header(FLASH_BASE, 0, 1);
    it.magic_last = ~MAGIC_LAST;
    enqueue(it);
    it = block_header(FLASH_BASE, 0, 1);
    it.flags = '1;
    enqueue(it);
    enqueue(block_header(FLASH_BASE + PAGE_BYTES / 2, 0, 1));
    it = block_header(FLASH_BASE, 0, 1);
    it.payload_bytes = '1;
    enqueue(it);
    it = block_header(FLASH_BASE, 0, 1);
    it.flags = 32'd1 << FLAG_FAMILY_BIT;
    it.family_tag = ~FAMILY_EXPECTED_RST;
    enqueue(it);
    // matching family tag, then an end with a block missing
    it = block_header(32'h1000_2000, 0, 2);
    it.flags = 32'd1 << FLAG_FAMILY_BIT;
    it.family_tag = FAMILY_EXPECTED_RST;
    enqueue(it);
    enqueue(link_item(MODE_END, '0));
    run_phase(0, 0, 250);

    // area wider than the flash: full-flash image and the top sector
    set_config('0, '1, '0);
    @(posedge clk);
    enqueue(block_header(FLASH_BASE, 0, FLASH_BYTES / PAGE_BYTES));
    enqueue(link_item(MODE_ABORT, '0));
    enqueue(block_header(FLASH_BASE + FLASH_BYTES - PAGE_BYTES, 0, 1));
    enqueue(link_item(MODE_END, '0));
    run_phase(67, 0, 250);

    set_config(32'h1008_0000, 32'h1010_0000, '1);
    run_phase(0, 67, 250);

    // inverted area: every header fails
    set_config('1, '0, $urandom());
    run_phase(25, 25, 30);

    set_config(FLASH_BASE + $urandom_range(FLASH_BYTES - 1), '0, $urandom());
    set_config(gen_begin, gen_begin + $urandom_range(PAGE_BYTES, 32'h4_0000), $urandom());
    run_phase(25, 25, 250);

    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && awaited_verdicts.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #RUN_LIMIT;
    $display("simulation failed");
    $finish;
  end

endmodule
